@@ sv/delta_variable_width_encoder_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the delta variable-width encoder
// Concurrent checks that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef DELTA_VARIABLE_WIDTH_ENCODER_UNIT_MACROS_SVH
`define DELTA_VARIABLE_WIDTH_ENCODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// cond must hold at every clock edge out of reset
`define DVWE_ASSERT_ALWAYS(lbl, clk_s, rstn_s, cond) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) \
        else $error("dvwe: invariant violated");

// cons must hold in the same cycle as ante
`define DVWE_ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("dvwe: implication violated");

`else

`define DVWE_ASSERT_ALWAYS(lbl, clk_s, rstn_s, cond)
`define DVWE_ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

@@ sv/dvwe_pkg.sv @@
// ---------------------------------------------------------------------------
// Delta variable-width encoder package
// Shared widths, register indexes, reset values and inter-module types.
// ---------------------------------------------------------------------------
package dvwe_pkg;

    localparam int MAX_SAMPLE_BITS = 32;
    localparam int SIZE_W          = 6;                    // word size registers
    localparam int MAG_W           = MAX_SAMPLE_BITS - 1;  // clamped magnitude
    localparam int WIDTH_W         = $clog2(MAX_SAMPLE_BITS);
    localparam int CODE_W          = 50;
    localparam int LEN_W           = 6;
    localparam int TAIL_W          = MAX_SAMPLE_BITS + 1;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SIZE_W-1:0] RESET_IN_WORD  = 6'd16;
    localparam logic [SIZE_W-1:0] RESET_OUT_WORD = 6'd12;
    localparam logic [SIZE_W-1:0] MIN_IN_WORD    = 6'd8;
    localparam logic [SIZE_W-1:0] MIN_OUT_WORD   = 6'd2;
    localparam logic [SIZE_W-1:0] MAX_WORD       = SIZE_W'(MAX_SAMPLE_BITS);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_WORD_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WORD_SIZE = 1'b1;

    // classified sample, front to back
    typedef struct packed {
        logic [MAG_W-1:0]   cmag;       // magnitude clamped to half-1
        logic [WIDTH_W-1:0] width;      // bit width of cmag
        logic               neg;        // delta sign
        logic               extra_en;   // extra bit present
        logic               extra_bit;  // delta was the most negative value
        logic               restart;    // clear previous width first
    } dvwe_item_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } dvwe_queue_stat_t;

endpackage

@@ sv/dvwe_front.sv @@
// ---------------------------------------------------------------------------
// Delta variable-width encoder front end
// Rescales each sample, forms the wrapped delta and classifies it.
// ---------------------------------------------------------------------------
module dvwe_front
    import dvwe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [SIZE_W-1:0]        iw,
    input  logic [SIZE_W-1:0]        ow,
    input  logic signed [MAX_SAMPLE_BITS-1:0] sample,
    input  logic                     restart,
    input  logic                     in_valid,
    output logic                     in_ready,
    output dvwe_item_t               item,
    output logic                     item_valid,
    input  logic                     item_ready
);

    function automatic logic [WIDTH_W-1:0] bit_width(input logic [MAG_W-1:0] v);
        logic [WIDTH_W-1:0] w;
        w = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (v[i])
                w = WIDTH_W'(i + 1);
        end
        return w;
    endfunction

    logic [SIZE_W-1:0]                 ext_sh;
    logic signed [MAX_SAMPLE_BITS-1:0] s_shl;
    logic signed [MAX_SAMPLE_BITS-1:0] s_ext;
    logic signed [MAX_SAMPLE_BITS-1:0] s_resc;
    logic [MAX_SAMPLE_BITS-1:0]        omask;
    logic [MAX_SAMPLE_BITS-1:0]        half;
    logic [MAX_SAMPLE_BITS-1:0]        prev_base;
    logic [MAX_SAMPLE_BITS-1:0]        delta_next;
    logic [MAX_SAMPLE_BITS-1:0]        mag;
    logic [MAX_SAMPLE_BITS-1:0]        cmag_full;
    logic                              neg;
    logic                              f1_load;
    logic                              f2_load;
    logic                              f1_ready;
    logic                              f2_ready;
    dvwe_item_t                        item_next;

    logic [MAX_SAMPLE_BITS-1:0] prev_sample_reg;
    logic                       f1_valid_reg;
    logic [MAX_SAMPLE_BITS-1:0] f1_delta_reg;
    logic                       f1_restart_reg;
    logic                       f2_valid_reg;
    dvwe_item_t                 f2_item_reg;

    // stage 1: sign extend, rescale, delta
    always_comb
    begin
        ext_sh = MAX_WORD - iw;
        s_shl  = sample << ext_sh;
        s_ext  = s_shl >>> ext_sh;
        if (ow > iw)
            s_resc = s_ext << (ow - iw);
        else
            s_resc = s_ext >>> (iw - ow);
        omask      = ~({MAX_SAMPLE_BITS{1'b1}} << ow);
        prev_base  = restart ? '0 : prev_sample_reg;
        delta_next = (MAX_SAMPLE_BITS'(s_resc) - prev_base) & omask;
    end

    // stage 2: sign, magnitude, width
    always_comb
    begin
        half      = MAX_SAMPLE_BITS'(1) << (ow - 1'b1);
        neg       = |(f1_delta_reg & half);
        mag       = neg ? ((MAX_SAMPLE_BITS'(0) - f1_delta_reg) & omask) : f1_delta_reg;
        cmag_full = (mag >= half) ? (half - 1'b1) : mag;
        item_next.cmag      = cmag_full[MAG_W-1:0];
        item_next.width     = bit_width(cmag_full[MAG_W-1:0]);
        item_next.neg       = neg;
        item_next.extra_en  = neg && (cmag_full == (half - 1'b1));
        item_next.extra_bit = (mag == half);
        item_next.restart   = f1_restart_reg;
    end

    assign f2_ready = !f2_valid_reg || item_ready;
    assign f1_ready = !f1_valid_reg || f2_ready;
    assign f2_load  = f1_valid_reg && f2_ready;
    assign f1_load  = in_valid && f1_ready;
    assign in_ready = f1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg <= '0;
            f1_valid_reg    <= 1'b0;
            f2_valid_reg    <= 1'b0;
        end
        else
        begin
            if (f1_load)
                prev_sample_reg <= MAX_SAMPLE_BITS'(s_resc);
            if (f1_ready)
                f1_valid_reg <= in_valid;
            if (f2_ready)
                f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f1_load)
        begin
            f1_delta_reg   <= delta_next;
            f1_restart_reg <= restart;
        end
        if (f2_load)
            f2_item_reg <= item_next;
    end

    assign item       = f2_item_reg;
    assign item_valid = f2_valid_reg;

endmodule

@@ sv/dvwe_queue.sv @@
// ---------------------------------------------------------------------------
// Delta variable-width encoder item queue
// Short FIFO that decouples the front end from the code builder.
// ---------------------------------------------------------------------------
module dvwe_queue
    import dvwe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dvwe_item_t       push_item,
    input  logic             pop,
    output dvwe_item_t       pop_item,
    output dvwe_queue_stat_t stat
);

    dvwe_item_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + 1'b1);
            if (pop)
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + 1'b1);
            if (push && !pop)
                count_reg <= QCNT_W'(count_reg + 1'b1);
            else if (pop && !push)
                count_reg <= QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    assign pop_item   = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

endmodule

@@ sv/dvwe_back.sv @@
// ---------------------------------------------------------------------------
// Delta variable-width encoder back end
// Codes the width change and packs the code word with its length.
// ---------------------------------------------------------------------------
module dvwe_back
    import dvwe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SIZE_W-1:0] ow,
    input  dvwe_item_t        item,
    input  logic              item_valid,
    output logic              item_ready,
    output logic [CODE_W-1:0] code_bits,
    output logic [LEN_W-1:0]  code_length,
    output logic              out_valid,
    input  logic              out_ready
);

    // v mod m for v below 32: restoring steps on a 4-bit quotient
    function automatic logic [WIDTH_W-1:0] reduce_width(input logic [WIDTH_W-1:0] v,
                                                        input logic [SIZE_W-1:0] m);
        logic [SIZE_W+2:0] r;
        logic [SIZE_W+2:0] d;
        r = (SIZE_W+3)'(v);
        for (int k = 3; k >= 0; k--)
        begin
            d = (SIZE_W+3)'(m) << k;
            if (r >= d)
                r = r - d;
        end
        return r[WIDTH_W-1:0];
    endfunction

    logic [WIDTH_W-1:0] last_raw;
    logic [WIDTH_W-1:0] last;
    logic [SIZE_W-1:0]  halfw;
    logic signed [7:0]  wd_raw;
    logic signed [7:0]  wd;
    logic signed [7:0]  wabs;
    logic signed [7:0]  halfw_s;
    logic signed [7:0]  ow_s;
    logic               wneg;
    logic [WIDTH_W-1:0] wmag;
    logic               stop;
    logic               has_sign;
    logic [1:0]         hval;
    logic [1:0]         hlen;
    logic [MAG_W-1:0]   body;
    logic [TAIL_W-1:0]  t1;
    logic [TAIL_W-1:0]  tail;
    logic [LEN_W-1:0]   tlen;
    logic               b1_load;
    logic               b2_load;
    logic               b1_ready;
    logic               b2_ready;

    logic [WIDTH_W-1:0] prev_width_reg;
    logic               b1_valid_reg;
    logic [WIDTH_W-1:0] b1_wmag_reg;
    logic [1:0]         b1_hval_reg;
    logic [1:0]         b1_hlen_reg;
    logic [TAIL_W-1:0]  b1_tail_reg;
    logic [LEN_W-1:0]   b1_tlen_reg;
    logic               out_valid_reg;
    logic [CODE_W-1:0]  code_bits_reg;
    logic [LEN_W-1:0]   code_length_reg;

    // stage 1: width change and the two parts of the code
    always_comb
    begin
        last_raw = item.restart ? '0 : prev_width_reg;
        last     = reduce_width(last_raw, ow);
        halfw    = ow >> 1;
        halfw_s  = signed'({2'b00, halfw});
        ow_s     = signed'({2'b00, ow});
        wd_raw   = signed'({3'b000, item.width}) - signed'({3'b000, last});
        if (wd_raw > halfw_s)
            wd = wd_raw - ow_s;
        else if (wd_raw < -halfw_s)
            wd = wd_raw + ow_s;
        else
            wd = wd_raw;
        wneg     = wd[7];
        wabs     = wneg ? -wd : wd;
        wmag     = wabs[WIDTH_W-1:0];
        stop     = ({1'b0, wmag} < halfw);
        has_sign = (wmag != '0);
        if (stop)
            hval = has_sign ? {1'b1, wneg} : 2'b01;
        else
            hval = {1'b0, wneg};
        hlen     = {1'b0, stop} + {1'b0, has_sign};

        // bits below the leading one, then the sign, then the extra bit
        body = item.cmag & ~(MAG_W'(1) << WIDTH_W'(item.width - 1'b1));
        t1   = {1'b0, body, item.neg};
        tail = item.extra_en ? {t1[TAIL_W-2:0], item.extra_bit} : t1;
        tlen = LEN_W'(item.width) + LEN_W'(item.extra_en);
    end

    assign b2_ready   = !out_valid_reg || out_ready;
    assign b1_ready   = !b1_valid_reg || b2_ready;
    assign b2_load    = b1_valid_reg && b2_ready;
    assign b1_load    = item_valid && b1_ready;
    assign item_ready = b1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_width_reg <= '0;
            b1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (b1_load)
                prev_width_reg <= item.width;
            if (b1_ready)
                b1_valid_reg <= item_valid;
            if (b2_ready)
                out_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b1_load)
        begin
            b1_wmag_reg <= wmag;
            b1_hval_reg <= hval;
            b1_hlen_reg <= hlen;
            b1_tail_reg <= tail;
            b1_tlen_reg <= tlen;
        end
        if (b2_load)
        begin
            code_bits_reg   <= (CODE_W'(b1_hval_reg) << b1_tlen_reg) | CODE_W'(b1_tail_reg);
            code_length_reg <= LEN_W'(b1_wmag_reg) + LEN_W'(b1_hlen_reg) + b1_tlen_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign code_bits   = code_bits_reg;
    assign code_length = code_length_reg;

endmodule

@@ sv/delta_variable_width_encoder_unit.sv @@
// ---------------------------------------------------------------------------
// Delta variable-width encoder: one code word per PCM sample
// Path: front f1/f2 stages, queue, back b1 and output registers. Throughput:
// one sample per cycle without output stalls, set by the two-stage front,
// 2-entry queue and two-stage back, each handing on one item per cycle.
// Reset: async active low; word sizes 16 and 12, previous sample/width zero.
// ---------------------------------------------------------------------------
`include "delta_variable_width_encoder_unit_macros.svh"

// Structure
//   front : sign extension from in_word_size, arithmetic rescale to
//           out_word_size, delta to the previous rescaled sample wrapped
//           modulo 2^out, then sign, clamped magnitude and its bit width.
//   queue : two entries; the front only pushes when there is room, so a
//           stall on the output reaches the input one queue later.
//   back  : width change against the previous width (reduced modulo out if
//           stale), wrapped into +-out/2, then the code word is packed into
//           the output register, first bit most significant, right-aligned.
// The previous sample lives in the front and the previous width in the back;
// the restart flag travels with the item so each side clears its own copy.
// Word sizes are saturated into their legal ranges where they are used.
// Configuration is always ready; a transfer lands the next cycle.
module delta_variable_width_encoder_unit
    import dvwe_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [CFG_IDX_W-1:0]              cfg_index,
    input  logic [SIZE_W-1:0]                 cfg_data,
    // samples
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [MAX_SAMPLE_BITS-1:0] sample,
    input  logic                              restart,
    // code words
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [CODE_W-1:0]                 code_bits,
    output logic [LEN_W-1:0]                  code_length
);

    logic [SIZE_W-1:0] in_word_size_reg;
    logic [SIZE_W-1:0] out_word_size_reg;
    logic [SIZE_W-1:0] iw;
    logic [SIZE_W-1:0] ow;

    dvwe_item_t       f_item;
    logic             f_item_valid;
    logic             f_item_ready;
    dvwe_item_t       q_item;
    logic             q_push;
    logic             q_pop;
    logic             b_item_ready;
    dvwe_queue_stat_t q_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_word_size_reg  <= RESET_IN_WORD;
            out_word_size_reg <= RESET_OUT_WORD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IN_WORD_SIZE:  in_word_size_reg  <= cfg_data;
                CFG_OUT_WORD_SIZE: out_word_size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // saturate word sizes into their legal ranges
    always_comb
    begin
        if (in_word_size_reg < MIN_IN_WORD)
            iw = MIN_IN_WORD;
        else if (in_word_size_reg > MAX_WORD)
            iw = MAX_WORD;
        else
            iw = in_word_size_reg;

        if (out_word_size_reg < MIN_OUT_WORD)
            ow = MIN_OUT_WORD;
        else if (out_word_size_reg > MAX_WORD)
            ow = MAX_WORD;
        else
            ow = out_word_size_reg;
    end

    dvwe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .iw         (iw),
        .ow         (ow),
        .sample     (sample),
        .restart    (restart),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item       (f_item),
        .item_valid (f_item_valid),
        .item_ready (f_item_ready)
    );

    // front transfers into the queue whenever there is room
    assign f_item_ready = !q_stat.full;
    assign q_push       = f_item_valid && f_item_ready;
    assign q_pop        = !q_stat.empty && b_item_ready;

    dvwe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (f_item),
        .pop       (q_pop),
        .pop_item  (q_item),
        .stat      (q_stat)
    );

    dvwe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .ow          (ow),
        .item        (q_item),
        .item_valid  (!q_stat.empty),
        .item_ready  (b_item_ready),
        .code_bits   (code_bits),
        .code_length (code_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

    // a code word is never empty and never longer than 49 bits
    `DVWE_ASSERT_IMPLIES(a_code_len_range, clk, rst_n, out_valid, (code_length != '0) && (code_length <= 6'd49))

    // nothing is set above the code length
    `DVWE_ASSERT_IMPLIES(a_code_aligned, clk, rst_n, out_valid, (code_bits >> code_length) == '0)

    // queue occupancy follows its transfers
    `DVWE_ASSERT_ALWAYS(a_queue_count, clk, rst_n, q_stat.count == QCNT_W'($past(q_stat.count) + $past(q_push) - $past(q_pop)))

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the delta variable-width encoder unit
// Drives PCM samples through the valid/ready channels under several word
// size settings and idling patterns. Every code word that leaves the block
// is compared field by field with a code computed alongside in the bench.
// ---------------------------------------------------------------------------
module testbench;
    import dvwe_pkg::*;

    // one expected code word
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  length;
    } code_word_t;

    // Scoreboard: shadow copy of the registers and the coding state, plus
    // the code words still owed by the block, oldest first.
    class code_word_tracker;
        logic [SIZE_W-1:0]          in_size;
        logic [SIZE_W-1:0]          out_size;
        logic [MAX_SAMPLE_BITS-1:0] last_sample;
        logic [SIZE_W-1:0]          last_width;
        code_word_t                 pending_codes[$];
        int                         mismatches;

        function new();
            in_size     = RESET_IN_WORD;
            out_size    = RESET_OUT_WORD;
            last_sample = '0;
            last_width  = '0;
            mismatches  = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
            if (idx == CFG_IN_WORD_SIZE)
                in_size = data;
            else if (idx == CFG_OUT_WORD_SIZE)
                out_size = data;
        endfunction

        // word sizes are saturated where they are used
        function int clamp_size(logic [SIZE_W-1:0] v, logic [SIZE_W-1:0] lo);
            if (v < lo)
                return int'(lo);
            if (v > MAX_WORD)
                return int'(MAX_WORD);
            return int'(v);
        endfunction

        // Works out the code word for one accepted sample and queues it.
        function void predict_code(logic [31:0] pcm, bit restart_flag);
            int          iw, ow, halfw, width, last, wd, wmag, len;
            bit          neg, wneg;
            logic [63:0] imask, omask, half, s, delta, mag, cmag, code;
            code_word_t  cw;

            iw    = clamp_size(in_size, MIN_IN_WORD);
            ow    = clamp_size(out_size, MIN_OUT_WORD);
            halfw = ow / 2;
            imask = (64'd1 << iw) - 64'd1;
            omask = (64'd1 << ow) - 64'd1;
            half  = 64'd1 << (ow - 1);

            if (restart_flag)
            begin
                last_sample = '0;
                last_width  = '0;
            end

            // sign extension from the input word, then arithmetic rescale
            s = 64'(pcm) & imask;
            if (s[iw-1])
                s = s | ~imask;
            if (ow > iw)
                s = s << (ow - iw);
            else
                s = 64'($signed(s) >>> (iw - ow));

            delta       = (s - 64'(last_sample)) & omask;
            last_sample = s[31:0];

            neg  = delta[ow-1];
            mag  = neg ? (((64'd1 << ow) - delta) & (omask | (64'd1 << ow))) : delta;
            cmag = (mag >= half) ? half - 64'd1 : mag;

            width = 0;
            while (width < 32 && (64'd1 << width) <= cmag)
                width++;

            // width change, stale width reduced first, wrapped into +-out/2
            last = int'(last_width);
            if (last >= ow)
                last = last % ow;
            wd         = width - last;
            last_width = SIZE_W'(width);
            if (wd > halfw)
                wd -= ow;
            else if (wd < -halfw)
                wd += ow;
            wneg = wd < 0;
            wmag = wneg ? -wd : wd;

            code = 64'd0 << 0;
            code = code << wmag;
            len  = wmag;
            if (wmag < halfw)
            begin
                code = (code << 1) | 64'd1;
                len++;
            end
            if (wmag != 0)
            begin
                code = (code << 1) | 64'(wneg);
                len++;
            end
            for (int i = 1; i < width; i++)
            begin
                code = (code << 1) | 64'(cmag[width-1-i]);
                len++;
            end
            if (cmag != 0)
            begin
                code = (code << 1) | 64'(neg);
                len++;
            end
            if (neg && cmag == half - 64'd1)
            begin
                code = (code << 1) | 64'(mag == half);
                len++;
            end

            cw.code   = code[CODE_W-1:0];
            cw.length = LEN_W'(len);
            pending_codes.push_back(cw);
        endfunction

        function void flag_error(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t ns: %s", $realtime, msg);
        endfunction

        function void check_code(logic [CODE_W-1:0] code_bits, logic [LEN_W-1:0] code_length);
            code_word_t exp_word;

            if (pending_codes.size() == 0)
            begin
                flag_error($sformatf("code word with none expected: bits %h length %0d",
                                     code_bits, code_length));
                return;
            end
            exp_word = pending_codes.pop_front();
            if (code_bits !== exp_word.code)
                flag_error($sformatf("code_bits expected %h got %h", exp_word.code, code_bits));
            if (code_length !== exp_word.length)
                flag_error($sformatf("code_length expected %0d got %0d",
                                     exp_word.length, code_length));
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Signals and the block
    // -----------------------------------------------------------------------
    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [CFG_IDX_W-1:0]              cfg_index;
    logic [SIZE_W-1:0]                 cfg_data;
    logic                              in_valid;
    logic                              in_ready;
    logic signed [MAX_SAMPLE_BITS-1:0] sample;
    logic                              restart;
    logic                              out_valid;
    logic                              out_ready;
    logic [CODE_W-1:0]                 code_bits;
    logic [LEN_W-1:0]                  code_length;

    code_word_tracker tracker = new();

    // idling, in percent of cycles
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    // input word size in force, saturated, for shaping the stimulus
    int          in_word_eff;
    // running waveform value for the smooth part of the stimulus
    logic [31:0] walk;

    delta_variable_width_encoder_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_bits   (code_bits),
        .code_length (code_length)
    );

    always #2 clk = ~clk;

    // -----------------------------------------------------------------------
    // Monitor: every transfer is taken at the rising edge, before the block's
    // registers move, so nothing here depends on event order within a step.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tracker.set_register(cfg_index, cfg_data);
            if (in_valid && in_ready)
                tracker.predict_code(sample, restart);
            if (out_valid && out_ready)
                tracker.check_code(code_bits, code_length);
        end
    end

    // Receiver back-pressure, redrawn every falling edge
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);

    // -----------------------------------------------------------------------
    // Driver tasks; all inputs move on the falling edge
    // -----------------------------------------------------------------------
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [SIZE_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random gap first (valid low), then one sample held until its transfer.
    // Valid is left high so back-to-back samples need no re-raise.
    task automatic send_sample(input logic [31:0] value, input bit flag);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        restart  <= flag;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every owed code word has left the block.
    // Each sample yields exactly one code word, so an empty queue means idle.
    task automatic wait_for_codes();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending_codes.size() != 0)
            @(posedge clk);
    endtask

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    // Directed samples at reset sizes (16 in, 12 out): field extremes, high
    // bits above the input word, a restart onto the most negative delta and
    // onto the next one up, and single-step deltas.
    localparam int DIRECTED_N = 14;
    logic [31:0] directed_samples [DIRECTED_N] = '{
        32'h0000_0000, 32'h0000_7FFF, 32'hFFFF_8000, 32'hFFFF_FFFF,
        32'h0000_8000, 32'h0000_0000, 32'hFFFF_8010, 32'hDEAD_1234,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0010, 32'h0000_0000,
        32'hAAAA_5555, 32'h5555_AAAA
    };
    bit directed_restart [DIRECTED_N] = '{
        1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
        1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1
    };

    // Register settings per phase, saturating values and an input size that
    // is not a byte multiple among them. Out size drops from 32 to 5 and from
    // 20 to 3 with no restart, so stale widths and samples get coded.
    localparam int PHASES     = 12;
    localparam int PHASE_ITEMS = 120;
    logic [SIZE_W-1:0] phase_in  [PHASES] = '{
        6'd16, 6'd8, 6'd32, 6'd24, 6'd0, 6'd63, 6'd13, 6'd32, 6'd8, 6'd24, 6'd16, 6'd40
    };
    logic [SIZE_W-1:0] phase_out [PHASES] = '{
        6'd12, 6'd2, 6'd32, 6'd5, 6'd63, 6'd0, 6'd31, 6'd8, 6'd20, 6'd3, 6'd16, 6'd7
    };

    initial
    begin
        int unsigned sel;
        logic [31:0] step;

        rst_n              = 1'b0;
        cfg_valid          = 1'b0;
        cfg_index          = CFG_IN_WORD_SIZE;
        cfg_data           = '0;
        in_valid           = 1'b0;
        sample             = '0;
        restart            = 1'b0;
        out_ready          = 1'b0;
        walk               = '0;
        in_word_eff        = int'(RESET_IN_WORD);
        sender_idle_pct    = 13;
        receiver_stall_pct = 80;

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int d = 0; d < DIRECTED_N; d++)
            send_sample(directed_samples[d], directed_restart[d]);
        wait_for_codes();

        for (int p = 0; p < PHASES; p++)
        begin
            // a third of the phases each: slow receiver, slow sender, no idling
            if (p < PHASES / 3)
            begin
                sender_idle_pct    = 13;
                receiver_stall_pct = 80;
            end
            else if (p < 2 * PHASES / 3)
            begin
                sender_idle_pct    = 80;
                receiver_stall_pct = 13;
            end
            else
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end

            // registers only change with the block drained
            write_register(CFG_IN_WORD_SIZE, phase_in[p]);
            write_register(CFG_OUT_WORD_SIZE, phase_out[p]);
            in_word_eff = (phase_in[p] < MIN_IN_WORD) ? int'(MIN_IN_WORD) :
                          (phase_in[p] > MAX_WORD) ? int'(MAX_WORD) : int'(phase_in[p]);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // mostly a waveform with steps of random width inside the
                // input word, some raw words, some word extremes
                sel = $urandom_range(99);
                if (sel < 60)
                begin
                    step = $urandom >> $urandom_range(31, 32 - in_word_eff);
                    if ($urandom_range(1) == 1)
                        step = -step;
                    walk = walk + step;
                end
                else if (sel < 85)
                    walk = $urandom;
                else
                begin
                    case ($urandom_range(3))
                        0:       walk = (32'd1 << (in_word_eff - 1)) - 32'd1;
                        1:       walk = -(32'd1 << (in_word_eff - 1));
                        2:       walk = '0;
                        default: walk = '1;
                    endcase
                end
                send_sample(walk, $urandom_range(99) < 3);
            end
            wait_for_codes();
        end

        // let the pipeline settle so any stray code word is caught
        repeat (20)
            @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_codes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
